// ===== src/fdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsc_pkg
// Shared types and constants of the header/trailer deframer with an additive
// checksum.
// ----------------------------------------------------------------------------
package fdsc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned DELAY_DEPTH = 3;
    localparam int unsigned CFG_IDX_W   = 2;

    // first position at which the first trailer byte may sit
    localparam logic [POS_W-1:0] TRAILER_POS = 3'd5;
    localparam logic [POS_W-1:0] POS_MAX     = 3'd7;
    // positions before this one emit nothing
    localparam logic [POS_W-1:0] EMIT_POS    = 3'd5;
    localparam logic [POS_W-1:0] POS_HEADER  = 3'd1;
    localparam logic [POS_W-1:0] POS_HUNT    = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST   = 2'd0,
        CFG_HEADER_SECOND  = 2'd1,
        CFG_TRAILER_FIRST  = 2'd2,
        CFG_TRAILER_SECOND = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] trailer_first;
        logic [BYTE_W-1:0] trailer_second;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_frame;
        logic              frame_ok;
    } t_result;

endpackage

// ===== src/fdsc_in_stage.sv =====
// ----------------------------------------------------------------------------
// fdsc_in_stage
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module fdsc_in_stage
    import fdsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== src/fdsc_core.sv =====
// ----------------------------------------------------------------------------
// fdsc_core
// Frame state: header hunt, saturating position count, three-byte delay line
// and running checksum. Produces at most one result per step.
// ----------------------------------------------------------------------------
module fdsc_core
    import fdsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic              r_prev_valid;
    logic              n_prev_valid;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] r_delay [DELAY_DEPTH];

    logic              w_in_frame;
    logic [POS_W-1:0]  w_pos_inc;
    logic [BYTE_W-1:0] w_prev;
    logic [BYTE_W-1:0] w_sum_add;
    logic              w_header_hit;
    logic              w_trailer_hit;

    // position 0 means hunting
    assign w_in_frame = (r_pos != POS_HUNT);
    assign w_pos_inc  = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_W'(1);
    // newest entry of the delay line is the previous byte
    assign w_prev     = r_delay[0];
    assign w_sum_add  = r_sum + r_delay[DELAY_DEPTH-1];

    assign w_header_hit  = r_prev_valid && (w_prev == i_cfg.header_first)
                           && (i_byte == i_cfg.header_second);
    assign w_trailer_hit = (w_pos_inc > TRAILER_POS) && (w_prev == i_cfg.trailer_first)
                           && (i_byte == i_cfg.trailer_second);

    always_comb begin
        n_pos                 = r_pos;
        n_prev_valid          = r_prev_valid;
        n_sum                 = r_sum;
        o_result.valid        = 1'b0;
        o_result.payload_byte = r_delay[DELAY_DEPTH-1];
        o_result.last_of_frame = 1'b0;
        o_result.frame_ok     = 1'b0;
        if (i_step) begin
            if (!w_in_frame) begin
                n_prev_valid = 1'b1;
                if (w_header_hit) begin
                    n_pos = POS_HEADER;
                    n_sum = '0;
                end
            end else begin
                n_pos = w_pos_inc;
                if (w_pos_inc >= EMIT_POS) begin
                    o_result.valid = 1'b1;
                    if (w_trailer_hit) begin
                        o_result.last_of_frame = 1'b1;
                        o_result.frame_ok      = (w_sum_add == r_delay[1]);
                        n_pos        = POS_HUNT;
                        n_prev_valid = 1'b0;
                        n_sum        = '0;
                    end else begin
                        n_sum = w_sum_add;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_HUNT;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
        end else begin
            r_pos        <= n_pos;
            r_prev_valid <= n_prev_valid;
            r_sum        <= n_sum;
        end
    end

    // every byte shifts in; a frame only reads entries written after its header
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_delay[0] <= i_byte;
            for (int i = 1; i < DELAY_DEPTH; i++) begin
                r_delay[i] <= r_delay[i-1];
            end
        end
    end

endmodule

// ===== src/frame_deframer_sum_checksum.sv =====
// ----------------------------------------------------------------------------
// frame_deframer_sum_checksum
// Byte-stream deframer with two-byte header and trailer and a modulo-256
// payload checksum.
// ----------------------------------------------------------------------------
// One received byte per transaction, one transaction per clock when the
// output side keeps up. A byte passes an input register, then the frame logic
// (a compare, an 8-bit add and the delay-line shift) into an output register.
// Payload bytes come out three received bytes late; the last one carries
// tlast, and tuser is 1 there when the checksum matched (frames with tuser
// low are to be dropped). The output register decouples the two sides: a new
// byte is taken while a result waits, and tready falls only when both
// registers are full.
module frame_deframer_sum_checksum
    import fdsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // received bytes
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
    // payload bytes
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata,   // [7:0] payload_byte
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser    // [0] frame_ok
);

    t_cfg              r_cfg;
    t_result           w_result;
    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_out_free;
    logic              w_advance;
    logic              w_load;

    logic              r_m_valid;
    logic [BYTE_W-1:0] r_m_data;
    logic              r_m_last;
    logic              r_m_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER_FIRST:   r_cfg.header_first   <= i_cfg_data;
                CFG_HEADER_SECOND:  r_cfg.header_second  <= i_cfg_data;
                CFG_TRAILER_FIRST:  r_cfg.trailer_first  <= i_cfg_data;
                CFG_TRAILER_SECOND: r_cfg.trailer_second <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_advance     = w_in_valid && w_out_free;
    assign s_axis_tready = !w_in_valid || w_advance;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    fdsc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_byte  (s_axis_tdata),
        .i_take  (w_advance),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    fdsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (w_in_byte),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_free) begin
            r_m_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_m_data <= w_result.payload_byte;
            r_m_last <= w_result.last_of_frame;
            r_m_ok   <= w_result.frame_ok;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_ok;

    // checksum verdict only ever rides on the last byte of a frame
    a_ok_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame_ok set on a byte that is not last of frame");

    // a held input byte is neither lost nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_valid && !w_advance |=> w_in_valid && $stable(w_in_byte))
        else $error("input register lost its byte while stalled");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule
